// ----- hdl/scmx_pkg.sv -----
package scmx_pkg;

    localparam logic [63:0] SEED_A    = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SEED_B    = 64'hD1B54A32D192ED03;
    localparam logic [63:0] MIX_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2  = 64'h94D049BB133111EB;
    localparam int unsigned SEED_ROT  = 7;

    // Configuration register indexes
    localparam int unsigned CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_KEY_PRIMARY   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_KEY_SECONDARY = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FILE_NONCE    = 2'd2;

    // Queue between front and back; depth must be a power of two
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        seed;
        logic        remix;
        logic [63:0] pos;
    } t_item;

    function automatic logic [63:0] rotl_seed(input logic [63:0] v);
        rotl_seed = {v[63-SEED_ROT:0], v[63:64-SEED_ROT]};
    endfunction

endpackage

// ----- hdl/scmx_front.sv -----
module scmx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  scmx_pkg::t_in       i_in_word,
    input  logic                i_q_full,
    output logic                o_q_wr,
    output scmx_pkg::t_item     o_q_item
);

    logic [63:0] r_pos;
    logic [63:0] n_pos;

    assign o_q_wr = i_push && !i_q_full;

    // Tag each word with its position and the mixing it needs
    always_comb begin
        o_q_item.data_byte = i_in_word.data_byte;
        o_q_item.last_byte = i_in_word.last_byte;
        o_q_item.pos       = r_pos;
        o_q_item.seed      = (r_pos == 64'd0);
        o_q_item.remix     = (r_pos[2:0] == 3'd0);
    end

    always_comb begin
        n_pos = r_pos;
        if (o_q_wr) begin
            n_pos = i_in_word.last_byte ? 64'd0 : r_pos + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 64'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ----- hdl/scmx_fifo.sv -----
module scmx_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  scmx_pkg::t_item   i_wr_item,
    input  logic              i_rd,
    output scmx_pkg::t_item   o_rd_item,
    output logic              o_full,
    output logic              o_empty
);

    scmx_pkg::t_item r_mem [scmx_pkg::QDEPTH];

    logic [scmx_pkg::QAW-1:0] r_wp;
    logic [scmx_pkg::QAW-1:0] r_rp;
    logic [scmx_pkg::QAW:0]   r_cnt;
    logic [scmx_pkg::QAW:0]   n_cnt;
    logic                     wr_en;
    logic                     rd_en;

    assign o_full    = (r_cnt == (scmx_pkg::QAW+1)'(scmx_pkg::QDEPTH));
    assign o_empty   = (r_cnt == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_item = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + (scmx_pkg::QAW+1)'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - (scmx_pkg::QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) begin
                r_wp <= r_wp + scmx_pkg::QAW'(1);
            end
            if (rd_en) begin
                r_rp <= r_rp + scmx_pkg::QAW'(1);
            end
        end
    end

endmodule

// ----- hdl/scmx_back.sv -----
module scmx_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [scmx_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [63:0]                 i_cfg_data,
    input  logic                        i_q_empty,
    input  scmx_pkg::t_item             i_q_item,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output scmx_pkg::t_out              o_out_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRE  = 3'd1;
    localparam logic [2:0] ST_M0   = 3'd2;
    localparam logic [2:0] ST_M1   = 3'd3;
    localparam logic [2:0] ST_M2   = 3'd4;
    localparam logic [2:0] ST_M3   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic            r_pass;
    logic            r_seedph;
    logic            r_out_valid;
    logic [63:0]     r_key_primary;
    logic [63:0]     r_key_secondary;
    logic [63:0]     r_file_nonce;
    logic [63:0]     r_word;
    logic [63:0]     r_v;
    logic [63:0]     r_prod;
    logic [63:0]     r_acc;
    scmx_pkg::t_item r_item;
    scmx_pkg::t_out  r_out;

    logic [63:0] seed_val;
    logic [63:0] pre_t;
    logic [63:0] mul_k;
    logic [31:0] mul_a;
    logic [31:0] mul_c;
    logic [63:0] mul_p;
    logic [31:0] acc_hi;
    logic [63:0] res;
    logic [63:0] w_mid;
    logic [63:0] w_fin;
    logic        out_ready;
    logic [7:0]  kbyte;

    assign seed_val = scmx_pkg::SEED_A ^ r_key_primary
                    ^ scmx_pkg::rotl_seed(r_key_secondary) ^ r_file_nonce;
    assign pre_t    = r_v + scmx_pkg::MIX_GAMMA;

    // Low 64 bits of r_v * K from three 32x32 partial products, one per cycle
    assign mul_k  = r_pass ? scmx_pkg::MIX_MUL2 : scmx_pkg::MIX_MUL1;
    assign mul_a  = (r_state == ST_M2) ? r_v[63:32] : r_v[31:0];
    assign mul_c  = (r_state == ST_M1) ? mul_k[63:32] : mul_k[31:0];
    assign mul_p  = {32'd0, mul_a} * {32'd0, mul_c};
    assign acc_hi = r_acc[63:32] + r_prod[31:0];
    assign res    = {acc_hi, r_acc[31:0]};
    assign w_mid  = res ^ (res >> 27);
    assign w_fin  = res ^ (res >> 31);

    assign out_ready  = !r_out_valid || i_pop;
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;
    assign kbyte      = r_word[{r_item.pos[2:0], 3'b000} +: 8];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_item.seed || i_q_item.remix) ? ST_PRE : ST_OUT;
                end
            end
            ST_PRE: n_state = ST_M0;
            ST_M0:  n_state = ST_M1;
            ST_M1:  n_state = ST_M2;
            ST_M2:  n_state = ST_M3;
            ST_M3: begin
                if (!r_pass) begin
                    n_state = ST_M0;
                end else if (r_seedph) begin
                    n_state = ST_PRE;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    r_item <= i_q_item;
                    if (i_q_item.seed) begin
                        r_v <= seed_val;
                    end else begin
                        r_v <= r_word + scmx_pkg::SEED_B + i_q_item.pos;
                    end
                end
            end
            ST_PRE: r_v <= pre_t ^ (pre_t >> 30);
            ST_M0:  r_prod <= mul_p;
            ST_M1: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            ST_M2: begin
                r_acc[63:32] <= acc_hi;
                r_prod       <= mul_p;
            end
            ST_M3: begin
                if (!r_pass) begin
                    r_v <= w_mid;
                end else if (r_seedph) begin
                    // seeded word goes straight into the group re-mix
                    r_v <= w_fin + scmx_pkg::SEED_B + r_item.pos;
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    r_out.out_byte <= r_item.data_byte ^ kbyte;
                    r_out.out_last <= r_item.last_byte;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_pass          <= 1'b0;
            r_seedph        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_word          <= 64'd0;
            r_key_primary   <= 64'd0;
            r_key_secondary <= 64'd0;
            r_file_nonce    <= 64'd0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_seedph <= i_q_item.seed;
            end else if (r_state == ST_M3 && r_pass) begin
                r_seedph <= 1'b0;
            end
            if (r_state == ST_PRE) begin
                r_pass <= 1'b0;
            end else if (r_state == ST_M3 && !r_pass) begin
                r_pass <= 1'b1;
            end
            if (r_state == ST_M3 && r_pass && !r_seedph) begin
                r_word <= w_fin;
            end
            if (r_state == ST_OUT && out_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    scmx_pkg::CFG_KEY_PRIMARY:   r_key_primary   <= i_cfg_data;
                    scmx_pkg::CFG_KEY_SECONDARY: r_key_secondary <= i_cfg_data;
                    scmx_pkg::CFG_FILE_NONCE:    r_file_nonce    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_mul_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_M0) |-> ($past(r_state) == ST_PRE || $past(r_state) == ST_M3))
        else $error("multiply entered from wrong state");

    a_seed_remix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_item.seed) |-> i_q_item.remix)
        else $error("seeded word without group re-mix");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_ready) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result word not loaded");

    a_word_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_M3 && r_pass && !r_seedph)
            |=> (r_state == ST_OUT && r_word == $past(w_fin)))
        else $error("keystream word not updated after mix");

endmodule

// ----- hdl/splitmix_keystream_byte_cipher.sv -----
// Byte-wise XOR stream cipher with a splitmix64 keystream; encrypt and
// decrypt are the same operation.
// Input channel: a word (data byte plus last-byte flag) is taken at a clock
// edge with push high and full low. Words enter a small queue, so a few
// can be pushed while the cipher core is busy.
// Result channel: while empty is low the oldest result is on o_out_word and
// it is taken at an edge with pop high. A stalled receiver holds the result
// register; the core waits for it, and once the queue fills, full rises.
// Configuration: key_primary, key_secondary and file_nonce are written at
// indexes 0..2 with cfg_valid (cfg_ready is always high); index 3 is
// ignored. Keys are read when a buffer's first byte is processed.
// Core: it uses one shared 32x32 multiplier, three partial products
// per 64-bit multiply and two multiplies per mix. A byte inside an 8-byte
// group goes straight to the output, a group's first byte runs the group
// mix first, a buffer's first byte the seed mix and then the group mix.
// Reset (synchronous, active low) clears the keys, the byte position, the
// queue and the result-valid flag.
module splitmix_keystream_byte_cipher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  scmx_pkg::t_in               i_in_word,
    output logic                        empty,
    input  logic                        pop,
    output scmx_pkg::t_out              o_out_word,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [scmx_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [63:0]                 i_cfg_data
);

    logic            q_wr;
    logic            q_rd;
    logic            q_empty;
    scmx_pkg::t_item q_wr_item;
    scmx_pkg::t_item q_rd_item;

    assign cfg_ready = 1'b1;

    scmx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_word (i_in_word),
        .i_q_full  (full),
        .o_q_wr    (q_wr),
        .o_q_item  (q_wr_item)
    );

    scmx_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_item (q_wr_item),
        .i_rd      (q_rd),
        .o_rd_item (q_rd_item),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    scmx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_item    (q_rd_item),
        .o_q_pop     (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_word  (o_out_word)
    );

endmodule
